>>> sv/wbmi_pkg.sv
// wbmi_pkg: shared types and constants for the weighted batch modular inverse sum block
// no dependencies; imported by the arithmetic unit, the sequencer, the top level and the testbench

package wbmi_pkg;

   // operations of the shared modular arithmetic unit
   typedef enum logic [1:0] {
      OP_REDUCE = 2'd0,
      OP_MUL    = 2'd1,
      OP_ADD    = 2'd2
   } op_type;

   // command from the sequencer to the arithmetic unit
   typedef struct packed {
      logic   start;
      op_type op;
   } unit_cmd_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_RED_A   = 4'd1,
      ST_RED_WP  = 4'd2,
      ST_RED_WB  = 4'd3,
      ST_RED_RP  = 4'd4,
      ST_RED_WN  = 4'd5,
      ST_MUL_W   = 4'd6,
      ST_MUL_T1  = 4'd7,
      ST_MUL_T2  = 4'd8,
      ST_ADD     = 4'd9,
      ST_MUL_RP  = 4'd10,
      ST_CHECK   = 4'd11,
      ST_POW_MUL = 4'd12,
      ST_POW_SQ  = 4'd13,
      ST_FINAL   = 4'd14,
      ST_OUT     = 4'd15
   } seq_state_type;

   // configuration register indexes
   localparam int          CSR_INDEX_BITS  = 1;
   localparam logic [0:0]  CSR_MODULUS     = 1'b0;
   localparam logic [0:0]  CSR_WEIGHT_BASE = 1'b1;

   // register reset values, cut to the value width where used
   localparam logic [63:0] MODULUS_RESET   = 64'd2147483647;
   localparam logic [63:0] WEIGHT_RESET    = 64'd1;

   // fermat exponent is the modulus less this offset
   localparam logic [63:0] EXP_OFFSET      = 64'd2;

endpackage

>>> sv/wbmi_mod_unit.sv
// wbmi_mod_unit: shared modular arithmetic unit (reduce, shift-and-add multiply, add)
// depends on wbmi_pkg for the command struct and operation codes

module wbmi_mod_unit
   import wbmi_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  unit_cmd_type          cmd,
   input  logic [VALUE_BITS-1:0] opa,
   input  logic [VALUE_BITS-1:0] opb,
   input  logic [VALUE_BITS-1:0] modulus,
   output logic                  done,
   output logic [VALUE_BITS-1:0] result
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   op_type                op_ff, op_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   logic                  mod_ok;
   logic [VALUE_BITS:0]   mod_ext;
   logic [VALUE_BITS:0]   cs_src;
   logic [VALUE_BITS:0]   cs_diff;
   logic [VALUE_BITS-1:0] cs_out;
   logic [VALUE_BITS:0]   dbl_src;
   logic [VALUE_BITS:0]   dbl_diff;
   logic [VALUE_BITS-1:0] dbl_out;

   // compare-subtract paths: one shared for reduce, add and accumulate, one for doubling
   always_comb begin
      mod_ok  = (modulus[VALUE_BITS-1:1] != '0);
      mod_ext = {1'b0, modulus};
      if (cmd.start) begin
         cs_src = {1'b0, opa} + {1'b0, opb};
      end else if (op_ff == OP_REDUCE) begin
         cs_src = {acc_ff, b_ff[VALUE_BITS-1]};
      end else begin
         cs_src = {1'b0, acc_ff} + {1'b0, a_ff};
      end
      cs_diff  = cs_src - mod_ext;
      cs_out   = (cs_src >= mod_ext) ? cs_diff[VALUE_BITS-1:0] : cs_src[VALUE_BITS-1:0];
      dbl_src  = {a_ff, 1'b0};
      dbl_diff = dbl_src - mod_ext;
      dbl_out  = (dbl_src >= mod_ext) ? dbl_diff[VALUE_BITS-1:0] : dbl_src[VALUE_BITS-1:0];
   end

   // start and iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         op_in = cmd.op;
         case (cmd.op)
            OP_REDUCE: begin
               if (!mod_ok) begin
                  acc_in  = '0;
                  done_in = 1'b1;
               end else if (opa < modulus) begin
                  acc_in  = opa;
                  done_in = 1'b1;
               end else begin
                  acc_in  = '0;
                  b_in    = opa;
                  cnt_in  = CW'(VALUE_BITS);
                  busy_in = 1'b1;
               end
            end
            OP_MUL: begin
               acc_in = '0;
               a_in   = opa;
               b_in   = opb;
               if (!mod_ok || (opb == '0)) begin
                  done_in = 1'b1;
               end else begin
                  busy_in = 1'b1;
               end
            end
            OP_ADD: begin
               acc_in  = mod_ok ? cs_out : '0;
               done_in = 1'b1;
            end
            default: begin
               acc_in  = '0;
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            OP_REDUCE: begin
               // restoring remainder, one dividend bit a cycle
               acc_in = cs_out;
               b_in   = {b_ff[VALUE_BITS-2:0], 1'b0};
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            OP_MUL: begin
               // one multiplier bit a cycle, stop once no set bits remain
               if (b_ff[0]) begin
                  acc_in = cs_out;
               end
               a_in = dbl_out;
               b_in = {1'b0, b_ff[VALUE_BITS-1:1]};
               if (b_ff[VALUE_BITS-1:1] == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_REDUCE;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

>>> sv/wbmi_seq.sv
// wbmi_seq: sequencer holding the stream state and driving the shared arithmetic unit
// depends on wbmi_pkg and instantiates wbmi_mod_unit

module wbmi_seq
   import wbmi_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_sum_value,
   output logic                  rsp_no_inverse,
   input  logic [VALUE_BITS-1:0] modulus,
   input  logic [VALUE_BITS-1:0] weight_base
);

   localparam logic [VALUE_BITS-1:0] ONE    = VALUE_BITS'(1);
   localparam logic [VALUE_BITS-1:0] OFFSET = EXP_OFFSET[VALUE_BITS-1:0];

   seq_state_type         state_ff, state_in;
   logic                  iss_ff, iss_in;
   logic                  last_ff, last_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] wp_ff, wp_in;
   logic [VALUE_BITS-1:0] wb_ff, wb_in;
   logic [VALUE_BITS-1:0] rp_ff, rp_in;
   logic [VALUE_BITS-1:0] wn_ff, wn_in;
   logic [VALUE_BITS-1:0] w_ff, w_in;
   logic [VALUE_BITS-1:0] t1_ff, t1_in;
   logic [VALUE_BITS-1:0] t2_ff, t2_in;
   logic [VALUE_BITS-1:0] pacc_ff, pacc_in;
   logic [VALUE_BITS-1:0] pbase_ff, pbase_in;
   logic [VALUE_BITS-1:0] e_ff, e_in;
   logic [VALUE_BITS-1:0] res_sum_ff, res_sum_in;
   logic                  res_ni_ff, res_ni_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_sum_ff, rsp_sum_in;
   logic                  rsp_ni_ff, rsp_ni_in;

   unit_cmd_type          cmd;
   logic [VALUE_BITS-1:0] opa;
   logic [VALUE_BITS-1:0] opb;
   logic                  uses_unit;
   logic                  unit_done;
   logic [VALUE_BITS-1:0] unit_result;
   logic                  op_fin;

   wbmi_mod_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .modulus(modulus),
      .done   (unit_done),
      .result (unit_result)
   );

   // next state, unit commands and data captures
   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      last_in      = last_ff;
      a_in         = a_ff;
      wp_in        = wp_ff;
      wb_in        = wb_ff;
      rp_in        = rp_ff;
      wn_in        = wn_ff;
      w_in         = w_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      pacc_in      = pacc_ff;
      pbase_in     = pbase_ff;
      e_in         = e_ff;
      res_sum_in   = res_sum_ff;
      res_ni_in    = res_ni_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_ni_in    = rsp_ni_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.start    = 1'b0;
      cmd.op       = OP_REDUCE;
      opa          = a_ff;
      opb          = a_ff;
      uses_unit    = 1'b0;

      // operand selection per step
      case (state_ff)
         ST_RED_A:   begin uses_unit = 1'b1; cmd.op = OP_REDUCE; opa = a_ff;    end
         ST_RED_WP:  begin uses_unit = 1'b1; cmd.op = OP_REDUCE; opa = wp_ff;   end
         ST_RED_WB:  begin uses_unit = 1'b1; cmd.op = OP_REDUCE; opa = weight_base; end
         ST_RED_RP:  begin uses_unit = 1'b1; cmd.op = OP_REDUCE; opa = rp_ff;   end
         ST_RED_WN:  begin uses_unit = 1'b1; cmd.op = OP_REDUCE; opa = wn_ff;   end
         ST_MUL_W: begin
            uses_unit = 1'b1; cmd.op = OP_MUL; opa = wp_ff; opb = wb_ff;
         end
         ST_MUL_T1: begin
            uses_unit = 1'b1; cmd.op = OP_MUL; opa = wn_ff; opb = a_ff;
         end
         ST_MUL_T2: begin
            uses_unit = 1'b1; cmd.op = OP_MUL; opa = w_ff; opb = rp_ff;
         end
         ST_ADD: begin
            uses_unit = 1'b1; cmd.op = OP_ADD; opa = t1_ff; opb = t2_ff;
         end
         ST_MUL_RP: begin
            uses_unit = 1'b1; cmd.op = OP_MUL; opa = rp_ff; opb = a_ff;
         end
         ST_POW_MUL: begin
            uses_unit = e_ff[0]; cmd.op = OP_MUL; opa = pacc_ff; opb = pbase_ff;
         end
         ST_POW_SQ: begin
            uses_unit = 1'b1; cmd.op = OP_MUL; opa = pbase_ff; opb = pbase_ff;
         end
         ST_FINAL: begin
            uses_unit = 1'b1; cmd.op = OP_MUL; opa = wn_ff; opb = pacc_ff;
         end
         default: begin
            uses_unit = 1'b0;
         end
      endcase

      // issue once per step, then wait for the unit
      op_fin = iss_ff && unit_done;
      if (uses_unit && !iss_ff) begin
         cmd.start = 1'b1;
         iss_in    = 1'b1;
      end
      if (op_fin) begin
         iss_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_value;
               last_in  = req_last;
               state_in = ST_RED_A;
            end
         end
         ST_RED_A: begin
            if (op_fin) begin a_in = unit_result; state_in = ST_RED_WP; end
         end
         ST_RED_WP: begin
            if (op_fin) begin wp_in = unit_result; state_in = ST_RED_WB; end
         end
         ST_RED_WB: begin
            if (op_fin) begin wb_in = unit_result; state_in = ST_RED_RP; end
         end
         ST_RED_RP: begin
            if (op_fin) begin rp_in = unit_result; state_in = ST_RED_WN; end
         end
         ST_RED_WN: begin
            if (op_fin) begin wn_in = unit_result; state_in = ST_MUL_W; end
         end
         ST_MUL_W: begin
            if (op_fin) begin w_in = unit_result; state_in = ST_MUL_T1; end
         end
         ST_MUL_T1: begin
            if (op_fin) begin t1_in = unit_result; state_in = ST_MUL_T2; end
         end
         ST_MUL_T2: begin
            if (op_fin) begin t2_in = unit_result; state_in = ST_ADD; end
         end
         ST_ADD: begin
            if (op_fin) begin wn_in = unit_result; state_in = ST_MUL_RP; end
         end
         ST_MUL_RP: begin
            if (op_fin) begin
               rp_in    = unit_result;
               wp_in    = w_ff;
               state_in = last_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            // product zero: no inverse, otherwise set up the fermat power
            if (rp_ff == '0) begin
               res_sum_in = '0;
               res_ni_in  = 1'b1;
               rp_in      = ONE;
               wn_in      = '0;
               wp_in      = ONE;
               state_in   = ST_OUT;
            end else begin
               pacc_in  = ONE;
               pbase_in = rp_ff;
               e_in     = modulus - OFFSET;
               state_in = (modulus == OFFSET) ? ST_FINAL : ST_POW_MUL;
            end
         end
         ST_POW_MUL: begin
            if (!e_ff[0] || op_fin) begin
               if (e_ff[0]) begin
                  pacc_in = unit_result;
               end
               state_in = (e_ff[VALUE_BITS-1:1] == '0) ? ST_FINAL : ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            if (op_fin) begin
               pbase_in = unit_result;
               e_in     = {1'b0, e_ff[VALUE_BITS-1:1]};
               state_in = ST_POW_MUL;
            end
         end
         ST_FINAL: begin
            if (op_fin) begin
               res_sum_in = unit_result;
               res_ni_in  = 1'b0;
               rp_in      = ONE;
               wn_in      = '0;
               wp_in      = ONE;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = res_sum_ff;
               rsp_ni_in    = res_ni_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rp_ff        <= ONE;
         wn_ff        <= '0;
         wp_ff        <= ONE;
      end else begin
         iss_ff       <= iss_in;
         rsp_valid_ff <= rsp_valid_in;
         rp_ff        <= rp_in;
         wn_ff        <= wn_in;
         wp_ff        <= wp_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      a_ff       <= a_in;
      wb_ff      <= wb_in;
      w_ff       <= w_in;
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      pacc_ff    <= pacc_in;
      pbase_ff   <= pbase_in;
      e_ff       <= e_in;
      res_sum_ff <= res_sum_in;
      res_ni_ff  <= res_ni_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_ni_ff  <= rsp_ni_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sum_value  = rsp_sum_ff;
   assign rsp_no_inverse = rsp_ni_ff;

endmodule

>>> sv/weighted_batch_modular_inverse_sum.sv
// weighted_batch_modular_inverse_sum: top level with configuration registers and sequencer
// depends on wbmi_pkg and instantiates wbmi_seq
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_value, req_last
//  rsp      out        rsp_valid / rsp_stall  rsp_sum_value, rsp_no_inverse
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// one transaction runs five reductions, four multiplies and one add on the shared unit;
// an operand (value, weight base or stream state) that is not below modulus is reduced by
// the bit-serial restoring remainder.
// a last transaction adds the fermat power, up to 2*VALUE_BITS multiplies.
// req_stall is high from acceptance until the transaction is done; a last one also waits for
// the output register, which buffers one result.
// synchronous reset restores modulus 2147483647, weight base 1 and an empty stream.
// csr_ready is always high; writes are expected only while the block is idle.

module weighted_batch_modular_inverse_sum
   import wbmi_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [VALUE_BITS-1:0]     req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [VALUE_BITS-1:0]     rsp_sum_value,
   output logic                      rsp_no_inverse,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]     csr_data
);

   logic [VALUE_BITS-1:0] modulus_ff, modulus_in;
   logic [VALUE_BITS-1:0] weight_ff, weight_in;

   // configuration writes
   always_comb begin
      modulus_in = modulus_ff;
      weight_in  = weight_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODULUS:     modulus_in = csr_data;
            CSR_WEIGHT_BASE: weight_in  = csr_data;
            default:         modulus_in = modulus_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[VALUE_BITS-1:0];
         weight_ff  <= WEIGHT_RESET[VALUE_BITS-1:0];
      end else begin
         modulus_ff <= modulus_in;
         weight_ff  <= weight_in;
      end
   end

   assign csr_ready = 1'b1;

   wbmi_seq #(
      .VALUE_BITS(VALUE_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_value (rsp_sum_value),
      .rsp_no_inverse(rsp_no_inverse),
      .modulus       (modulus_ff),
      .weight_base   (weight_ff)
   );

endmodule

>>> sv/wbmi_checker.sv
// wbmi_checker: port-level assertions for the weighted batch modular inverse sum block
// depends only on the top level's ports; bound to the top level by the bind statement below

module wbmi_checker #(
   parameter int VALUE_BITS = 31
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [VALUE_BITS-1:0] rsp_sum_value,
   input logic                  rsp_no_inverse,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_value) && $stable(rsp_no_inverse))
      else $error("result changed while stalled");

   // a missing inverse always reports a zero sum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_inverse |-> rsp_sum_value == '0)
      else $error("no-inverse result with nonzero sum");

   // an accepted transaction keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready straight after a transaction");

   // configuration writes are always taken
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write not taken");

   // reset leaves the block idle with no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind weighted_batch_modular_inverse_sum wbmi_checker #(
   .VALUE_BITS(VALUE_BITS)
) u_wbmi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_sum_value (rsp_sum_value),
   .rsp_no_inverse(rsp_no_inverse),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready)
);

>>> test/tb_weighted_batch_modular_inverse_sum.sv
`timescale 1ns / 100ps
// testbench for weighted_batch_modular_inverse_sum: streams of values are checked against
// a self-contained predictor of the weighted inverse sum; depends on wbmi_pkg and the block

module tb_weighted_batch_modular_inverse_sum
   import wbmi_pkg::*;
();

   localparam int VB            = 31;
   localparam int SETTLE_CYCLES = 300;    // one transaction, value above modulus included
   localparam int IDLE_LIMIT    = 40000;  // full fermat power plus the longest receiver hold
   localparam int HOLD_CYCLES   = 8000;
   localparam int RANDOM_ITEMS  = 600;
   localparam bit [VB-1:0] ALL_ONES  = {VB{1'b1}};
   localparam bit [VB-1:0] MAX_PRIME = 31'd2147483647;

   typedef struct {
      bit [VB-1:0] sum_value;
      bit          no_inverse;
   } sum_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [VB-1:0]             req_value = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [VB-1:0]             rsp_sum_value;
   logic                      rsp_no_inverse;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MODULUS;
   logic [VB-1:0]             csr_data = '0;

   // predictor copy of the registers and the stream state
   bit [VB-1:0] modulus_reg      = MAX_PRIME;
   bit [VB-1:0] weight_base_reg  = 31'd1;
   bit [VB-1:0] stream_product   = 31'd1;
   bit [VB-1:0] stream_numerator = 31'd0;
   bit [VB-1:0] stream_power     = 31'd1;

   sum_result_type expected_sums[$];
   sum_result_type front;
   int          error_count   = 0;
   int          burst_left    = 0;
   int          hold_request  = 0;
   int          hold_left     = 0;
   int          idle_cycles   = 0;

   weighted_batch_modular_inverse_sum #(
      .VALUE_BITS(VB)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sum_value  (rsp_sum_value),
      .rsp_no_inverse (rsp_no_inverse),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // residue arithmetic; a modulus below two maps everything to zero
   function automatic bit [63:0] reduce_mod(input bit [63:0] x);
      if (modulus_reg < 2) return 64'd0;
      return x % {33'd0, modulus_reg};
   endfunction

   function automatic bit [63:0] mul_mod(input bit [63:0] a, input bit [63:0] b);
      return reduce_mod(reduce_mod(a) * reduce_mod(b));
   endfunction

   function automatic bit [63:0] pow_mod(input bit [63:0] base, input bit [63:0] e);
      bit [63:0] acc;
      acc  = reduce_mod(64'd1);
      base = reduce_mod(base);
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, base);
         base = mul_mod(base, base);
         e    = e >> 1;
      end
      return acc;
   endfunction

   // fold one value into the stream; a last value queues the expected sum
   function automatic void advance_stream(input bit [VB-1:0] value, input bit last);
      bit [63:0]      a;
      bit [63:0]      w;
      bit [63:0]      prod;
      sum_result_type res;
      a = reduce_mod(64'(value));
      w = mul_mod(64'(stream_power), 64'(weight_base_reg));
      stream_numerator = VB'(reduce_mod(mul_mod(64'(stream_numerator), a) +
                                        mul_mod(w, 64'(stream_product))));
      stream_product   = VB'(mul_mod(64'(stream_product), a));
      stream_power     = VB'(w);
      if (last) begin
         prod = reduce_mod(64'(stream_product));
         if (prod == 0) begin
            res.sum_value  = '0;
            res.no_inverse = 1'b1;
         end else begin
            res.sum_value  = VB'(mul_mod(64'(stream_numerator),
                                         pow_mod(prod, {33'd0, modulus_reg} - 64'd2)));
            res.no_inverse = 1'b0;
         end
         expected_sums.push_back(res);
         stream_product   = 31'd1;
         stream_numerator = 31'd0;
         stream_power     = 31'd1;
      end
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, what);
   endtask

   // one input transaction, with random bursts and gaps on the sender side
   task automatic send_item(input bit [VB-1:0] value, input bit last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                                  : int'($urandom_range(1, 6));
         gap        = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 250));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_value <= value;
      req_last  <= last;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_stream(value, last);
   endtask

   // wait for every pending sum, then let any unfinished transaction settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input bit [VB-1:0] modulus, input bit [VB-1:0] weight_base);
      csr_valid <= 1'b1;
      csr_index <= CSR_MODULUS;
      csr_data  <= modulus;
      do @(posedge clock); while (csr_ready !== 1'b1);
      modulus_reg = modulus;
      csr_index <= CSR_WEIGHT_BASE;
      csr_data  <= weight_base;
      do @(posedge clock); while (csr_ready !== 1'b1);
      weight_base_reg = weight_base;
      csr_valid <= 1'b0;
   endtask

   function automatic bit [VB-1:0] pick_value(input bit [VB-1:0] modulus);
      case ($urandom_range(0, 19))
         0:             return '0;
         1:             return modulus;
         2:             return modulus - 1'b1;
         3:             return ALL_ONES;
         4, 5, 6, 7, 8: return VB'($urandom >> 1);
         default:       return (modulus >= 2) ? VB'($urandom_range(1, modulus - 1))
                                              : VB'($urandom >> 1);
      endcase
   endfunction

   // registers at their reset values; a value equal to the modulus gives no inverse
   task automatic test_default_registers();
      send_item(31'd1, 1'b1);
      send_item(MAX_PRIME - 1'b1, 1'b0);
      send_item(31'd3, 1'b1);
      send_item(ALL_ONES, 1'b1);
      wait_idle();
   endtask

   // zero inside a stream, then a clean stream after it; zero weight base
   task automatic test_zero_values();
      configure(MAX_PRIME, MAX_PRIME - 1'b1);
      send_item(31'd5, 1'b0);
      send_item(31'd0, 1'b0);
      send_item(31'd9, 1'b1);
      send_item(31'h5555_5555, 1'b0);
      send_item(31'h2AAA_AAAA, 1'b1);
      wait_idle();
      configure(31'd1000000007, 31'd0);
      send_item(31'd12, 1'b0);
      send_item(31'd34, 1'b1);
      wait_idle();
   endtask

   // modulus zero and one, the smallest prime, weight base above the modulus
   task automatic test_tiny_moduli();
      configure(31'd0, 31'd3);
      send_item(31'd4, 1'b1);
      wait_idle();
      configure(31'd1, 31'd0);
      send_item(31'd6, 1'b1);
      wait_idle();
      configure(31'd2, 31'd1);
      send_item(31'd1, 1'b1);
      wait_idle();
      configure(31'd3, ALL_ONES);
      send_item(31'd2, 1'b0);
      send_item(ALL_ONES, 1'b1);
      wait_idle();
   endtask

   // stream state left above a smaller modulus; a composite modulus
   task automatic test_modulus_change();
      configure(MAX_PRIME, 31'd12345);
      send_item(MAX_PRIME - 1'b1, 1'b0);
      send_item(31'h4000_0000, 1'b0);
      wait_idle();
      configure(31'd101, 31'd12345);
      send_item(31'd7, 1'b1);
      wait_idle();
      configure(31'd15, 31'd2);
      send_item(31'd4, 1'b0);
      send_item(31'd7, 1'b1);
      wait_idle();
   endtask

   // random settings per phase, random streams of mostly short length
   task automatic test_random_streams();
      int          items_done;
      int          phase_items;
      int          len;
      bit [VB-1:0] modulus;
      bit [VB-1:0] weight_base;
      items_done = 0;
      while (items_done < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       modulus = MAX_PRIME;
            1:       modulus = 31'd2147483629;
            2:       modulus = 31'd1000000007;
            3:       modulus = 31'd65521;
            4:       modulus = VB'($urandom_range(2, 255));
            5:       modulus = 31'd251;
            6, 7:    modulus = VB'($urandom >> 1);
            8:       modulus = 31'd13;
            default: modulus = VB'($urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 5))
            0:       weight_base = '0;
            1:       weight_base = 31'd1;
            2:       weight_base = modulus - 1'b1;
            3:       weight_base = ALL_ONES;
            default: weight_base = VB'($urandom >> 1);
         endcase
         configure(modulus, weight_base);
         phase_items = 0;
         while (phase_items < 40) begin
            len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(7, 24))
                                              : int'($urandom_range(1, 6));
            for (int i = 0; i < len; i++) send_item(pick_value(modulus), i == len - 1);
            phase_items += len;
         end
         items_done += phase_items;
         wait_idle();
      end
   endtask

   // receiver holds off while single-value streams keep coming, so the block backs up
   task automatic test_result_backpressure();
      configure(MAX_PRIME, VB'($urandom >> 1));
      hold_request = HOLD_CYCLES;
      burst_left   = 10;
      for (int i = 0; i < 5; i++) send_item(pick_value(MAX_PRIME), 1'b1);
      wait_idle();
   endtask

   // receiver stall pattern, with an occasional long hold on request
   initial begin : result_receiver
      int pattern_left;
      int stall_pct;
      pattern_left = 0;
      stall_pct    = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (pattern_left == 0) begin
               pattern_left = $urandom_range(16, 400);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 30;
                  2:       stall_pct = 70;
                  default: stall_pct = 97;
               endcase
            end
            pattern_left--;
            rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
         end
      end
   end

   // compare each result transaction with the oldest pending sum
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_sums.size() == 0) begin
            report_mismatch("result transaction with no stream ending pending");
         end else begin
            front = expected_sums.pop_front();
            if (rsp_sum_value !== front.sum_value)
               report_mismatch($sformatf("sum_value %0d, expected %0d",
                                         rsp_sum_value, front.sum_value));
            if (rsp_no_inverse !== front.no_inverse)
               report_mismatch($sformatf("no_inverse %b, expected %b",
                                         rsp_no_inverse, front.no_inverse));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("weighted_batch_modular_inverse_sum: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_registers();
      test_zero_values();
      test_tiny_moduli();
      test_modulus_change();
      test_result_backpressure();
      test_random_streams();
      wait_idle();
      if (error_count == 0)
         $display("weighted_batch_modular_inverse_sum: match");
      else
         $display("weighted_batch_modular_inverse_sum: mismatch");
      $finish;
   end

endmodule

>>> weighted_batch_modular_inverse_sum.f
sv/wbmi_pkg.sv
sv/wbmi_mod_unit.sv
sv/wbmi_seq.sv
sv/weighted_batch_modular_inverse_sum.sv
sv/wbmi_checker.sv
test/tb_weighted_batch_modular_inverse_sum.sv
